// ----- rtl/lrtpe_pkg.sv -----
package lrtpe_pkg;

  localparam int DEF_NUM_STATES     = 64;
  localparam int DEF_NUM_SYMBOLS    = 128;
  localparam int DEF_STACK_DEPTH    = 64;
  localparam int DEF_MAX_REDUCTIONS = 15;

  localparam int KIND_W   = 2;
  localparam int STIDX_W  = 6;
  localparam int SYM_W    = 7;
  localparam int ATYPE_W  = 2;
  localparam int TGT_W    = 7;
  localparam int LEN_W    = 4;
  localparam int EVENT_W  = 3;
  localparam int TOP_W    = 6;

  localparam logic [KIND_W-1:0] KIND_ACT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GOTO  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TOKEN = 2'd2;

  localparam logic [ATYPE_W-1:0] ACT_EMPTY  = 2'd0;
  localparam logic [ATYPE_W-1:0] ACT_SHIFT  = 2'd1;
  localparam logic [ATYPE_W-1:0] ACT_REDUCE = 2'd2;
  localparam logic [ATYPE_W-1:0] ACT_ACCEPT = 2'd3;

  localparam logic [EVENT_W-1:0] EV_SHIFT  = 3'd0;
  localparam logic [EVENT_W-1:0] EV_REDUCE = 3'd1;
  localparam logic [EVENT_W-1:0] EV_ACCEPT = 3'd2;
  localparam logic [EVENT_W-1:0] EV_NOACT  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_CHAIN  = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [STIDX_W-1:0] state_index;
    logic [SYM_W-1:0]   symbol;
    logic [ATYPE_W-1:0] entry_action;
    logic [TGT_W-1:0]   entry_target;
    logic [LEN_W-1:0]   entry_length;
  } in_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic [TOP_W-1:0]   top_state;
    logic [SYM_W-1:0]   rule_head;
    logic [LEN_W-1:0]   rule_length;
    logic               last;
  } out_t;

  // action table entry: length in 12..9, target in 8..2, type in 1..0
  typedef struct packed {
    logic [LEN_W-1:0]   length;
    logic [TGT_W-1:0]   target;
    logic [ATYPE_W-1:0] atype;
  } act_entry_t;

  localparam int ACT_ENTRY_W = $bits(act_entry_t);

endpackage

// ----- rtl/lrtpe_ram.sv -----
module lrtpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lrtpe_clear.sv -----
module lrtpe_clear #(
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     rst_n,
  output logic                     busy,
  output logic [$clog2(DEPTH)-1:0] addr
);

  localparam int AW = $clog2(DEPTH);

  logic          busy_r;
  logic          busy_nxt;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] addr_nxt;

  always_comb begin
    busy_nxt = busy_r;
    addr_nxt = addr_r;
    if (busy_r) begin
      // drop busy after the last entry
      if (addr_r == AW'(DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        addr_nxt = AW'(addr_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      addr_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      addr_r <= addr_nxt;
    end
  end

  assign busy = busy_r;
  assign addr = addr_r;

endmodule

// ----- rtl/lr_table_parse_engine_unit.sv -----
// Table-driven LR shift-reduce parser. Kind 0 and 1 requests write one action or goto entry.
// A kind 2 request feeds one token: the engine emits one result per reduction (last = 0)
// and then one final shift, accept or error result (last = 1). Each reduction runs the chain
// action read -> stack read -> goto read through memories with registered reads; results
// wait in an output register while the output is stalled. After reset the action table is
// swept to empty, one entry a cycle over all NUM_STATES*NUM_SYMBOLS entries (8192 by
// default), and in_ready stays low during the sweep. Goto entries read before being written
// return undefined states.
module lr_table_parse_engine_unit
  import lrtpe_pkg::*;
#(
  parameter int NUM_STATES     = DEF_NUM_STATES,
  parameter int NUM_SYMBOLS    = DEF_NUM_SYMBOLS,
  parameter int STACK_DEPTH    = DEF_STACK_DEPTH,
  parameter int MAX_REDUCTIONS = DEF_MAX_REDUCTIONS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int TBL_DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int AW  = $clog2(TBL_DEPTH);
  localparam int SW  = $clog2(NUM_STATES);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int SPW = $clog2(STACK_DEPTH);
  localparam int RW  = $clog2(MAX_REDUCTIONS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ACT   = 2'd1;
  localparam logic [1:0] S_BELOW = 2'd2;
  localparam logic [1:0] S_GOTO  = 2'd3;

  function automatic logic [AW-1:0] tbl_addr(input int unsigned st, input int unsigned sy);
    return AW'(st * NUM_SYMBOLS + sy);
  endfunction

  logic [1:0]       state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [SW-1:0]    top_r, top_nxt;
  logic [RW-1:0]    red_r, red_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic             sym_bad_r, sym_bad_nxt;
  logic [TGT_W-1:0] head_r, head_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [CW-1:0]    ncnt_r, ncnt_nxt;
  logic             bzero_r, bzero_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic             clr_busy;
  logic [AW-1:0]    clr_addr;

  logic             act_we, act_re;
  logic [AW-1:0]    act_waddr, act_raddr;
  act_entry_t       act_wdata, act_rdata;
  logic             ld_act_we;
  logic             got_we, got_re;
  logic [AW-1:0]    got_raddr;
  logic [TGT_W-1:0] got_rdata;
  logic [AW-1:0]    ld_addr;
  logic             stk_we, stk_re;
  logic [SPW-1:0]   stk_waddr, stk_raddr;
  logic [SW-1:0]    stk_wdata, stk_rdata;

  logic             in_fire;
  logic             out_free;
  logic             emit;
  out_t             emit_d;
  logic [CW-1:0]    red_cnt;
  logic [SW-1:0]    below;
  logic             ld_ok;

  assign in_ready = (state_r == S_IDLE) && !clr_busy;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign ld_addr  = tbl_addr(32'(in_data.state_index), 32'(in_data.symbol));
  assign ld_ok    = (32'(in_data.state_index) < NUM_STATES) &&
                    (32'(in_data.symbol) < NUM_SYMBOLS);
  assign red_cnt  = CW'(32'(cnt_r) - 32'(act_rdata.length));
  assign below    = bzero_r ? '0 : stk_rdata;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    top_nxt     = top_r;
    red_nxt     = red_r;
    sym_nxt     = sym_r;
    sym_bad_nxt = sym_bad_r;
    head_nxt    = head_r;
    len_nxt     = len_r;
    ncnt_nxt    = ncnt_r;
    bzero_nxt   = bzero_r;
    emit        = 1'b0;
    emit_d      = '0;
    ld_act_we   = 1'b0;
    got_we      = 1'b0;
    act_re      = 1'b0;
    act_raddr   = tbl_addr(32'(top_r), 32'(in_data.symbol));
    got_re      = 1'b0;
    got_raddr   = tbl_addr(32'(below), 32'(head_r));
    stk_we      = 1'b0;
    stk_waddr   = SPW'(cnt_r);
    stk_wdata   = SW'(act_rdata.target);
    stk_re      = 1'b0;
    stk_raddr   = SPW'(32'(red_cnt) - 1);

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.kind)
            KIND_ACT:  ld_act_we = ld_ok;
            KIND_GOTO: got_we    = ld_ok;
            KIND_TOKEN: begin
              sym_nxt     = in_data.symbol;
              sym_bad_nxt = 32'(in_data.symbol) >= NUM_SYMBOLS;
              red_nxt     = '0;
              act_re      = 1'b1;
              state_nxt   = S_ACT;
            end
            default: ;
          endcase
        end
      end
      S_ACT: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_d.last      = 1'b1;
          emit_d.event_res = EV_CHAIN;
          state_nxt        = S_IDLE;
          cnt_nxt          = CW'(1);
          top_nxt          = '0;
          if (sym_bad_r || act_rdata.atype == ACT_EMPTY) begin
            emit_d.event_res = EV_NOACT;
          end else if (act_rdata.atype == ACT_ACCEPT) begin
            emit_d.event_res = EV_ACCEPT;
          end else if (act_rdata.atype == ACT_SHIFT) begin
            if (32'(act_rdata.target) < NUM_STATES && 32'(cnt_r) < STACK_DEPTH) begin
              stk_we           = 1'b1;
              cnt_nxt          = CW'(32'(cnt_r) + 1);
              top_nxt          = SW'(act_rdata.target);
              emit_d.event_res = EV_SHIFT;
              emit_d.top_state = TOP_W'(SW'(act_rdata.target));
            end
          end else begin
            // reduce: fetch the state exposed after popping the body
            if (32'(red_r) < MAX_REDUCTIONS &&
                32'(act_rdata.length) < 32'(cnt_r) &&
                32'(red_cnt) < STACK_DEPTH &&
                32'(act_rdata.target) < NUM_SYMBOLS) begin
              emit      = 1'b0;
              cnt_nxt   = cnt_r;
              top_nxt   = top_r;
              stk_re    = 1'b1;
              bzero_nxt = (red_cnt == CW'(1));
              head_nxt  = act_rdata.target;
              len_nxt   = act_rdata.length;
              ncnt_nxt  = red_cnt;
              state_nxt = S_BELOW;
            end
          end
        end
      end
      S_BELOW: begin
        got_re    = 1'b1;
        state_nxt = S_GOTO;
      end
      S_GOTO: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_d.last = 1'b1;
          if (32'(got_rdata) >= NUM_STATES) begin
            emit_d.event_res = EV_CHAIN;
            cnt_nxt          = CW'(1);
            top_nxt          = '0;
            state_nxt        = S_IDLE;
          end else begin
            // push goto state and look up the same token again
            stk_we             = 1'b1;
            stk_waddr          = SPW'(ncnt_r);
            stk_wdata          = SW'(got_rdata);
            cnt_nxt            = CW'(32'(ncnt_r) + 1);
            top_nxt            = SW'(got_rdata);
            red_nxt            = RW'(32'(red_r) + 1);
            emit_d.event_res   = EV_REDUCE;
            emit_d.top_state   = TOP_W'(SW'(got_rdata));
            emit_d.rule_head   = head_r;
            emit_d.rule_length = len_r;
            emit_d.last        = 1'b0;
            act_re             = 1'b1;
            act_raddr          = tbl_addr(32'(got_rdata), 32'(sym_r));
            state_nxt          = S_ACT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = emit_d;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CW'(1);
      top_r       <= '0;
      red_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      top_r       <= top_nxt;
      red_r       <= red_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r     <= sym_nxt;
    sym_bad_r <= sym_bad_nxt;
    head_r    <= head_nxt;
    len_r     <= len_nxt;
    ncnt_r    <= ncnt_nxt;
    bzero_r   <= bzero_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // the sweep owns the action write port until it is done
  assign act_we    = clr_busy || ld_act_we;
  assign act_waddr = clr_busy ? clr_addr : ld_addr;
  assign act_wdata = clr_busy ? act_entry_t'('0) :
                     act_entry_t'{length: in_data.entry_length,
                                  target: in_data.entry_target,
                                  atype:  in_data.entry_action};

  lrtpe_clear #(
    .DEPTH(TBL_DEPTH)
  ) u_clear (
    .clk  (clk),
    .rst_n(rst_n),
    .busy (clr_busy),
    .addr (clr_addr)
  );

  lrtpe_ram #(
    .WIDTH(ACT_ENTRY_W),
    .DEPTH(TBL_DEPTH)
  ) u_act_ram (
    .clk  (clk),
    .we   (act_we),
    .waddr(act_waddr),
    .wdata(act_wdata),
    .re   (act_re),
    .raddr(act_raddr),
    .rdata(act_rdata)
  );

  lrtpe_ram #(
    .WIDTH(TGT_W),
    .DEPTH(TBL_DEPTH)
  ) u_goto_ram (
    .clk  (clk),
    .we   (got_we),
    .waddr(ld_addr),
    .wdata(in_data.entry_target),
    .re   (got_re),
    .raddr(got_raddr),
    .rdata(got_rdata)
  );

  lrtpe_ram #(
    .WIDTH(SW),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .re   (stk_re),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

endmodule
